// ===== rtl/hcd_pkg.sv =====
// Shared types, constants and helper functions of the chunked response deframer.
// Used by the channel interfaces, the parse step and the top level; depends on nothing.
package hcd_pkg;

  // Width of the chunk size counter.
  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  // Configuration register indexes.
  localparam logic CFG_CHUNKED_MODE = 1'b0;
  localparam logic CFG_HEADERS_ONLY = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_RAW    = 6'b000010,
    PH_SIZE   = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_TRAIL  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [7:0]           older_byte;
    logic [7:0]           previous_byte;
    logic [SIZE_BITS-1:0] chunk_remaining;
    logic                 final_chunk_seen;
    logic                 overflow_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:            PH_HEADER,
    older_byte:       8'h00,
    previous_byte:    8'h00,
    chunk_remaining:  {SIZE_BITS{1'b0}},
    final_chunk_seen: 1'b0,
    overflow_flag:    1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       header_end;
    logic       size_overflow;
  } result_t;

  typedef struct packed {
    logic chunked_mode;
    logic headers_only;
  } cfg_t;

  // Returns {is_hex, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'h00;
    case (c) inside
      [8'h30:8'h39]: res = {1'b1, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: res = {1'b1, c[3:0] + 4'd9};
      default: res = 5'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/hcd_channels.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on hcd_pkg for the result kind type.
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_message;

  modport source (output valid, output rx_byte, output new_message, input ready);
  modport sink (input valid, input rx_byte, input new_message, output ready);
endinterface

interface hcd_out_if;
  logic          valid;
  logic          ready;
  logic [7:0]    out_byte;
  hcd_pkg::kind_t kind;
  logic          header_end;
  logic          size_overflow;

  modport source (output valid, output out_byte, output kind, output header_end,
                  output size_overflow, input ready);
  modport sink (input valid, input out_byte, input kind, input header_end,
                input size_overflow, output ready);
endinterface

// ===== rtl/hcd_step.sv =====
// One parse step: next parser state and the optional result for one received byte.
// Purely combinational; depends on hcd_pkg.
module hcd_step (
  input  hcd_pkg::state_t  cur,
  input  hcd_pkg::cfg_t    cfg,
  input  logic [7:0]       rx_byte,
  input  logic             new_message,
  output hcd_pkg::state_t  nxt,
  output hcd_pkg::result_t res,
  output logic             emit
);

  hcd_pkg::state_t st;
  logic            hdr_end;
  logic [4:0]      hex;

  assign st  = new_message ? hcd_pkg::STATE_RESET : cur;
  assign hex = hcd_pkg::hex_digit(rx_byte);
  assign hdr_end = (st.previous_byte == hcd_pkg::CH_LF && rx_byte == hcd_pkg::CH_LF) ||
                   (st.older_byte == hcd_pkg::CH_LF && st.previous_byte == hcd_pkg::CH_CR &&
                    rx_byte == hcd_pkg::CH_LF);

  always_comb begin
    nxt  = st;
    emit = 1'b0;
    res  = '{out_byte: rx_byte, kind: hcd_pkg::KIND_HEADER, header_end: 1'b0,
             size_overflow: 1'b0};
    unique case (st.phase)
      hcd_pkg::PH_HEADER: begin
        emit           = 1'b1;
        res.header_end = hdr_end;
        if (hdr_end) begin
          if (cfg.headers_only) begin
            nxt.phase = hcd_pkg::PH_DONE;
          end else if (cfg.chunked_mode) begin
            nxt.phase           = hcd_pkg::PH_SIZE;
            nxt.chunk_remaining = '0;
            nxt.overflow_flag   = 1'b0;
          end else begin
            nxt.phase = hcd_pkg::PH_RAW;
          end
        end else begin
          nxt.older_byte    = st.previous_byte;
          nxt.previous_byte = rx_byte;
        end
      end
      hcd_pkg::PH_RAW: begin
        emit     = 1'b1;
        res.kind = hcd_pkg::KIND_BODY;
      end
      hcd_pkg::PH_SIZE: begin
        if (hex[4]) begin
          // Any nonzero bit in the top digit is shifted out by this digit.
          if (st.chunk_remaining[hcd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
            nxt.overflow_flag = 1'b1;
          end
          nxt.chunk_remaining = {st.chunk_remaining[hcd_pkg::SIZE_BITS-5:0], hex[3:0]};
        end else if (rx_byte == hcd_pkg::CH_LF) begin
          if (st.chunk_remaining == '0) begin
            nxt.final_chunk_seen = 1'b1;
            nxt.phase            = hcd_pkg::PH_TRAIL;
          end else begin
            nxt.phase = hcd_pkg::PH_DATA;
          end
        end
      end
      hcd_pkg::PH_DATA: begin
        emit                = 1'b1;
        res.kind            = hcd_pkg::KIND_BODY;
        res.size_overflow   = st.overflow_flag;
        nxt.chunk_remaining = st.chunk_remaining - 1'b1;
        if (st.chunk_remaining == {{(hcd_pkg::SIZE_BITS-1){1'b0}}, 1'b1}) begin
          nxt.phase = hcd_pkg::PH_TRAIL;
        end
      end
      hcd_pkg::PH_TRAIL: begin
        if (rx_byte == hcd_pkg::CH_LF) begin
          if (st.final_chunk_seen) begin
            nxt.phase         = hcd_pkg::PH_DONE;
            emit              = 1'b1;
            res.out_byte      = hcd_pkg::CH_LF;
            res.kind          = hcd_pkg::KIND_END;
            res.size_overflow = st.overflow_flag;
          end else begin
            nxt.phase           = hcd_pkg::PH_SIZE;
            nxt.chunk_remaining = '0;
            nxt.overflow_flag   = 1'b0;
          end
        end
      end
      default: begin
        // Finished: bytes are dropped until the next message starts.
        nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/http_response_chunked_deframer.sv =====
// Top level of the HTTP response deframer with chunked transfer decoding.
// Depends on hcd_pkg, the channel interfaces and hcd_step.
//
// Usage:
//   in_chan carries one received response byte per item, with new_message set on
//   the first byte of each response. out_chan carries forwarded header bytes,
//   body bytes and the end marker of a chunked body; bytes of chunk size lines,
//   chunk trailers and anything after the end produce no item.
//   cfg_we/cfg_index/cfg_wdata write chunked_mode (index 0) and headers_only
//   (index 1); write them only while no item is in flight.
// Timing:
//   An accepted item lands in an input register and is parsed from there by hcd_step;
//   its result, if any, is written to the output register, from which out_chan takes it.
//   One item can be accepted every cycle while out_chan is not stalled; the parser state
//   update is combinational logic in hcd_step.
// Reset and stalls:
//   Reset empties both registers, clears the configuration and puts the parser
//   in header phase. While out_chan is stalled the output register holds its item
//   and the input register absorbs one more byte before in_chan.ready drops.
module http_response_chunked_deframer (
  input  logic              clk,
  input  logic              rst_n,
  hcd_in_if.sink            in_chan,
  hcd_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_wdata
);

  hcd_pkg::cfg_t    cfg_r;
  hcd_pkg::state_t  state_r;
  hcd_pkg::state_t  state_nxt;
  hcd_pkg::result_t out_r;
  hcd_pkg::result_t res;
  logic             emit;
  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             in_new_r;
  logic             out_v_r;
  logic             advance;

  assign advance       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || advance;

  hcd_step u_step (
    .cur         (state_r),
    .cfg         (cfg_r),
    .rx_byte     (in_byte_r),
    .new_message (in_new_r),
    .nxt         (state_nxt),
    .res         (res),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == hcd_pkg::CFG_CHUNKED_MODE) begin
        cfg_r.chunked_mode <= cfg_wdata;
      end else begin
        cfg_r.headers_only <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= hcd_pkg::STATE_RESET;
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (advance) begin
        state_r <= state_nxt;
        out_v_r <= emit;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
      in_new_r  <= in_chan.new_message;
    end
    if (advance && emit) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.out_byte      = out_r.out_byte;
  assign out_chan.kind          = out_r.kind;
  assign out_chan.header_end    = out_r.header_end;
  assign out_chan.size_overflow = out_r.size_overflow;

endmodule
